// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, off during reset.
`define RPB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check an implication on every clock edge, off during reset.
`define RPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/rpb_pkg.sv
// Shared constants and types of the probe pair blender.
`timescale 1ns / 1ps
package rpb_pkg;

  localparam int MAX_PROBES = 16;
  localparam int SLOT_W     = $clog2(MAX_PROBES);
  localparam int CNT_W      = 5;
  localparam int W_W        = 17;
  localparam int DIV_N_W    = 48;
  localparam int DIV_D_W    = 31;
  localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;

  // One table entry as written by a load request.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        hx;
    logic [30:0]        hy;
    logic [30:0]        hz;
    logic [30:0]        fade;
    logic signed [15:0] rank;
  } probe_t;

  // What the cell holding the walk token shows to the walker.
  typedef struct packed {
    logic signed [33:0] min_edge;
    logic [30:0]        fade;
    logic signed [15:0] rank;
  } cell_sel_t;

endpackage

// File: sv/rpb_div.sv
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
`timescale 1ns / 1ps
module rpb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rpb_pkg::DIV_N_W-1:0] num_i,
  input  logic [rpb_pkg::DIV_D_W-1:0] den_i,
  output logic                       done_o,
  output logic [rpb_pkg::W_W-1:0]    quot_o
);

  logic                        busy_q;
  logic [4:0]                  cnt_q;
  logic [31:0]                 rem_q;
  logic [rpb_pkg::W_W-1:0]     low_q;
  logic [rpb_pkg::W_W-1:0]     quot_q;
  logic [rpb_pkg::DIV_D_W-1:0] den_q;
  logic [31:0]                 trial;
  logic                        fits;

  assign trial = {rem_q[30:0], low_q[rpb_pkg::W_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(rpb_pkg::W_W);
    end else if (busy_q) begin
      if (cnt_q == 5'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i[rpb_pkg::DIV_N_W-1:rpb_pkg::W_W]};
      low_q  <= num_i[rpb_pkg::W_W-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q && cnt_q != 5'd0) begin
      rem_q  <= fits ? trial - {1'b0, den_q} : trial;
      low_q  <= {low_q[rpb_pkg::W_W-2:0], 1'b0};
      quot_q <= {quot_q[rpb_pkg::W_W-2:0], fits};
    end
  end

  assign done_o = busy_q && cnt_q == 5'd0;
  assign quot_o = quot_q;

endmodule

// File: sv/rpb_cell.sv
// One probe cell: holds an entry, its edge distance to the query and a walk token.
`timescale 1ns / 1ps
module rpb_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  rpb_pkg::probe_t            entry_i,
  input  logic signed [31:0]         qx_i,
  input  logic signed [31:0]         qy_i,
  input  logic signed [31:0]         qz_i,
  input  logic                       tok_clear_i,
  input  logic                       tok_first_i,
  input  logic                       tok_adv_i,
  input  logic                       tok_i,
  output logic                       tok_o,
  output rpb_pkg::cell_sel_t         sel_o
);

  rpb_pkg::probe_t    entry_q;
  logic               tok_q;
  logic signed [33:0] min_edge_q;
  logic signed [33:0] ex, ey, ez, mxy, mall;

  function automatic logic signed [33:0] axis_edge(input logic signed [31:0] p,
                                                  input logic signed [31:0] c,
                                                  input logic [30:0] h);
    logic signed [32:0] d;
    logic [32:0]        mag;
    d   = 33'(p) - 33'(c);
    mag = d[32] ? 33'(-d) : 33'(d);
    return $signed({3'b000, h}) - $signed({1'b0, mag});
  endfunction

  assign ex   = axis_edge(qx_i, entry_q.cx, entry_q.hx);
  assign ey   = axis_edge(qy_i, entry_q.cy, entry_q.hy);
  assign ez   = axis_edge(qz_i, entry_q.cz, entry_q.hz);
  assign mxy  = (ex < ey) ? ex : ey;
  assign mall = (mxy < ez) ? mxy : ez;

  always_ff @(posedge clk_i) begin
    if (wr_i) entry_q <= entry_i;
    min_edge_q <= mall;
  end

  // On a clear, place the token in the first cell; hand it to the next cell on each advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (tok_clear_i) begin
      tok_q <= tok_first_i;
    end else if (tok_adv_i) begin
      tok_q <= tok_i;
    end
  end

  assign tok_o          = tok_q;
  assign sel_o.min_edge = tok_q ? min_edge_q : '0;
  assign sel_o.fade     = tok_q ? entry_q.fade : '0;
  assign sel_o.rank     = tok_q ? entry_q.rank : '0;

endmodule

// File: sv/reflection_probe_pair_blend.sv
// Top level: box probe table as a chain of cells and the query walker.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | op, slot, coord, extent, blend, rank
//   out     | output    | out_valid_o / out_stall_i| hit_count, slots, weights
//   cfg     | input     | cfg_we_i                 | walk length
//
// A query walks edge, then per probe a probe and an update state (with a divide
// between them when its influence needs the shared serial divider), then finish,
// a weight normalization divide when two probes are kept, and done.
// Reset clears control state and the walk length; table entries are undefined.
// A waiting result does not block the next request; a finished query holds
// until the output register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module reflection_probe_pair_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [3:0]          slot_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic signed [31:0]  coord_z_i,
  input  logic [30:0]         extent_x_i,
  input  logic [30:0]         extent_y_i,
  input  logic [30:0]         extent_z_i,
  input  logic [30:0]         blend_width_i,
  input  logic signed [15:0]  rank_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          hit_count_o,
  output logic [3:0]          first_slot_o,
  output logic [3:0]          second_slot_o,
  output logic [16:0]         first_weight_o,
  output logic [16:0]         second_weight_o
);

  localparam int N  = rpb_pkg::MAX_PROBES;
  localparam int SW = rpb_pkg::SLOT_W;
  localparam int CW = rpb_pkg::CNT_W;
  localparam int WW = rpb_pkg::W_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGE, ST_PROBE, ST_DIV, ST_UPDATE, ST_FINISH, ST_NORM, ST_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      walk_len_q;
  logic [CW-1:0]      limit;
  logic signed [31:0] qx_q, qy_q, qz_q;
  logic [SW-1:0]      idx_q;
  logic [WW-1:0]      inf_q;
  logic [1:0]         cnt_q;
  logic [SW-1:0]      i0_q, i1_q;
  logic [WW-1:0]      w0_q, w1_q;
  logic signed [15:0] rank_cur_q;
  logic               rank_set_q;
  logic [WW-1:0]      fw_q;

  logic               in_acc;
  rpb_pkg::probe_t    entry;
  logic [N-1:0]       tok;
  rpb_pkg::cell_sel_t cell_sel [N];
  rpb_pkg::cell_sel_t sel;
  logic               tok_clear, tok_adv, last;

  logic               div_start, div_done;
  logic [rpb_pkg::DIV_N_W-1:0] div_num;
  logic [rpb_pkg::DIV_D_W-1:0] div_den;
  logic [WW-1:0]      div_quot;

  logic               edge_pos, hard, full;
  logic               swap;
  logic [WW-1:0]      wa, wb;
  logic [SW-1:0]      ia, ib;
  logic [WW:0]        total;
  logic               repl_second;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign limit      = (walk_len_q > CW'(N)) ? CW'(N) : walk_len_q;

  assign entry.cx   = coord_x_i;
  assign entry.cy   = coord_y_i;
  assign entry.cz   = coord_z_i;
  assign entry.hx   = extent_x_i;
  assign entry.hy   = extent_y_i;
  assign entry.hz   = extent_z_i;
  assign entry.fade = blend_width_i;
  assign entry.rank = rank_i;

  assign tok_clear = state_q == ST_EDGE;
  assign last      = ({1'b0, idx_q} + CW'(1)) == limit;

  for (genvar g = 0; g < N; g++) begin : g_cell
    rpb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_i        (in_acc && !op_i && slot_i == 4'(g)),
      .entry_i     (entry),
      .qx_i        (qx_q),
      .qy_i        (qy_q),
      .qz_i        (qz_q),
      .tok_clear_i (tok_clear),
      .tok_first_i (g == 0),
      .tok_adv_i   (tok_adv),
      .tok_i       ((g == 0) ? 1'b0 : tok[(g == 0) ? 0 : g-1]),
      .tok_o       (tok[g]),
      .sel_o       (cell_sel[g])
    );
  end

  // Only the token cell drives nonzero values, so an OR picks it.
  always_comb begin
    sel = '0;
    for (int k = 0; k < N; k++) sel = sel | cell_sel[k];
  end

  assign edge_pos = sel.min_edge > 34'sd0;
  assign hard     = sel.fade == '0;
  assign full     = sel.min_edge >= $signed({3'b000, sel.fade});

  assign swap  = w1_q > w0_q;
  assign wa    = swap ? w1_q : w0_q;
  assign wb    = swap ? w0_q : w1_q;
  assign ia    = swap ? i1_q : i0_q;
  assign ib    = swap ? i0_q : i1_q;
  assign total = {1'b0, wa} + {1'b0, wb};
  assign repl_second = !(w0_q <= w1_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_q == ST_PROBE && edge_pos && !hard && !full) begin
      div_start = 1'b1;
      div_num   = rpb_pkg::DIV_N_W'({sel.min_edge[30:0], 16'h0000});
      div_den   = sel.fade;
    end else if (state_q == ST_FINISH && cnt_q == 2'd2) begin
      div_start = 1'b1;
      div_num   = ({31'd0, wa} << 16) + rpb_pkg::DIV_N_W'(total >> 1);
      div_den   = rpb_pkg::DIV_D_W'(total);
    end
  end

  rpb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Advance the token when a probe is done and the walk goes on.
  always_comb begin
    tok_adv = 1'b0;
    if (state_q == ST_UPDATE && !last) begin
      if (inf_q == '0 || !rank_set_q || sel.rank == rank_cur_q) tok_adv = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      walk_len_q    <= '0;
      out_valid_o   <= 1'b0;
      cnt_q         <= '0;
      rank_set_q    <= 1'b0;
      idx_q         <= '0;
    end else begin
      if (cfg_we_i) walk_len_q <= cfg_wdata_i;
      if (out_valid_o && !out_stall_i && state_q != ST_DONE) out_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && op_i) begin
            qx_q       <= coord_x_i;
            qy_q       <= coord_y_i;
            qz_q       <= coord_z_i;
            cnt_q      <= '0;
            rank_set_q <= 1'b0;
            idx_q      <= '0;
            i0_q       <= '0;
            i1_q       <= '0;
            w0_q       <= '0;
            w1_q       <= '0;
            state_q    <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          state_q <= (limit == '0) ? ST_FINISH : ST_PROBE;
        end
        ST_PROBE: begin
          if (!edge_pos) begin
            inf_q   <= '0;
            state_q <= ST_UPDATE;
          end else if (hard || full) begin
            inf_q   <= rpb_pkg::ONE_Q16;
            state_q <= ST_UPDATE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            inf_q   <= div_quot;
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (inf_q != '0 && rank_set_q && sel.rank != rank_cur_q) begin
            state_q <= ST_FINISH;
          end else begin
            if (inf_q != '0) begin
              if (!rank_set_q) begin
                rank_set_q <= 1'b1;
                rank_cur_q <= sel.rank;
              end
              if (cnt_q == 2'd0) begin
                i0_q  <= idx_q;
                w0_q  <= inf_q;
                cnt_q <= 2'd1;
              end else if (cnt_q == 2'd1) begin
                i1_q  <= idx_q;
                w1_q  <= inf_q;
                cnt_q <= 2'd2;
              end else if (!repl_second && inf_q > w0_q) begin
                i0_q <= idx_q;
                w0_q <= inf_q;
              end else if (repl_second && inf_q > w1_q) begin
                i1_q <= idx_q;
                w1_q <= inf_q;
              end
            end
            if (last) begin
              state_q <= ST_FINISH;
            end else begin
              idx_q   <= idx_q + SW'(1);
              state_q <= ST_PROBE;
            end
          end
        end
        ST_FINISH: begin
          i0_q    <= ia;
          i1_q    <= ib;
          fw_q    <= rpb_pkg::ONE_Q16;
          state_q <= (cnt_q == 2'd2) ? ST_NORM : ST_DONE;
        end
        ST_NORM: begin
          if (div_done) begin
            fw_q    <= div_quot;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o     <= 1'b1;
            hit_count_o     <= cnt_q;
            first_slot_o    <= (cnt_q != 2'd0) ? 4'(i0_q) : 4'd0;
            second_slot_o   <= (cnt_q == 2'd2) ? 4'(i1_q) : 4'd0;
            first_weight_o  <= (cnt_q != 2'd0) ? fw_q : '0;
            second_weight_o <= (cnt_q == 2'd2) ? rpb_pkg::ONE_Q16 - fw_q : '0;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `RPB_ASSERT(a_tok_onehot, clk_i, rst_ni, $onehot0(tok))
  `RPB_ASSERT_IMP(a_one_hit, clk_i, rst_ni, out_valid_o && hit_count_o == 2'd1,
                  first_weight_o == rpb_pkg::ONE_Q16 && second_weight_o == '0)
  `RPB_ASSERT_IMP(a_pair_sum, clk_i, rst_ni, out_valid_o && hit_count_o == 2'd2,
                  first_weight_o + second_weight_o == rpb_pkg::ONE_Q16)
  `RPB_ASSERT_IMP(a_no_div_idle, clk_i, rst_ni, state_q == ST_IDLE, !div_done)

endmodule
